/* hdl/md5_pkg.sv */
package md5_pkg;

  localparam int WordW  = 32;
  localparam int Steps  = 64;
  localparam int StepW  = $clog2(Steps);
  localparam int MsgW   = 4;
  localparam int ChainW = 2;
  localparam int RotW   = 5;

  typedef enum logic [1:0] {
    REQ_LOAD_CHAIN = 2'd0,
    REQ_LOAD_MSG   = 2'd1,
    REQ_COMPUTE    = 2'd2,
    REQ_UNUSED     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_INIT   = 2'd1,
    ST_ROUND  = 2'd2,
    ST_FINISH = 2'd3
  } state_t;

  typedef struct packed {
    logic             ld_chain;
    logic             ld_msg;
    logic             init;
    logic             round;
    logic             finish;
    logic [StepW-1:0] step;
  } dp_cmd_t;

  localparam logic [MsgW-1:0] WORD_ORDER [Steps] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd1, 4'd6, 4'd11, 4'd0, 4'd5, 4'd10, 4'd15, 4'd4,
    4'd9, 4'd14, 4'd3, 4'd8, 4'd13, 4'd2, 4'd7, 4'd12,
    4'd5, 4'd8, 4'd11, 4'd14, 4'd1, 4'd4, 4'd7, 4'd10,
    4'd13, 4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15, 4'd2,
    4'd0, 4'd7, 4'd14, 4'd5, 4'd12, 4'd3, 4'd10, 4'd1,
    4'd8, 4'd15, 4'd6, 4'd13, 4'd4, 4'd11, 4'd2, 4'd9
  };

  localparam logic [RotW-1:0] ROT_AMOUNT [Steps] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd7, 5'd12, 5'd17, 5'd22,
    5'd7, 5'd12, 5'd17, 5'd22, 5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9, 5'd14, 5'd20, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd5, 5'd9, 5'd14, 5'd20, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd4, 5'd11, 5'd16, 5'd23,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21, 5'd6, 5'd10, 5'd15, 5'd21,
    5'd6, 5'd10, 5'd15, 5'd21, 5'd6, 5'd10, 5'd15, 5'd21
  };

  localparam logic [WordW-1:0] SINE_CONST [Steps] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  function automatic logic [WordW-1:0] mix_fn(input logic [StepW-1:0] step,
                                              input logic [WordW-1:0] x,
                                              input logic [WordW-1:0] y,
                                              input logic [WordW-1:0] z);
    logic [WordW-1:0] r;
    case (step[StepW-1:StepW-2])
      2'd0:    r = (x & y) | (~x & z);
      2'd1:    r = (x & z) | (y & ~z);
      2'd2:    r = x ^ y ^ z;
      default: r = y ^ (x | ~z);
    endcase
    return r;
  endfunction

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v,
                                            input logic [RotW-1:0] n);
    logic [2*WordW-1:0] dbl;
    dbl = {v, v} << n;
    return dbl[2*WordW-1:WordW];
  endfunction

endpackage

/* hdl/md5_ctrl.sv */
module md5_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [1:0]            req_type,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output md5_pkg::dp_cmd_t      cmd
);
  import md5_pkg::*;

  state_t           state, state_next;
  logic [StepW-1:0] step, step_next;
  logic             out_valid_next;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    step_next      = step;
    out_valid_next = out_valid && out_stall;
    in_stall       = 1'b1;
    accept         = 1'b0;
    cmd            = '0;
    cmd.step       = step;
    case (state)
      ST_IDLE: begin
        in_stall     = 1'b0;
        accept       = in_valid;
        cmd.ld_chain = accept && (req_t'(req_type) == REQ_LOAD_CHAIN);
        cmd.ld_msg   = accept && (req_t'(req_type) == REQ_LOAD_MSG);
        if (accept && (req_t'(req_type) == REQ_COMPUTE)) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        step_next  = '0;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        step_next = step + 1'b1;
        if (step == StepW'(Steps - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold here until the output register is free
        if (!out_valid || !out_stall) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* hdl/md5_dp.sv */
module md5_dp (
  input  logic                      clk,
  input  md5_pkg::dp_cmd_t          cmd,
  input  logic [md5_pkg::MsgW-1:0]  word_index,
  input  logic [md5_pkg::WordW-1:0] word_value,
  output logic [md5_pkg::WordW-1:0] digest_a,
  output logic [md5_pkg::WordW-1:0] digest_b,
  output logic [md5_pkg::WordW-1:0] digest_c,
  output logic [md5_pkg::WordW-1:0] digest_d
);
  import md5_pkg::*;

  logic [WordW-1:0] chain [4];
  logic [WordW-1:0] msg [16];
  logic [WordW-1:0] a, b, c, d;
  // a + M[g] + K of the coming step, registered ahead of that step
  logic [WordW-1:0] pre, pre_next;
  logic [StepW-1:0] step_ahead;
  logic [WordW-1:0] sum, b_new;

  assign step_ahead = cmd.init ? '0 : cmd.step + 1'b1;
  assign pre_next   = (cmd.init ? chain[0] : d) + msg[WORD_ORDER[step_ahead]]
                      + SINE_CONST[step_ahead];
  assign sum        = pre + mix_fn(cmd.step, b, c, d);
  assign b_new      = b + rotl(sum, ROT_AMOUNT[cmd.step]);

  always_ff @(posedge clk) begin
    if (cmd.ld_chain) begin
      chain[word_index[ChainW-1:0]] <= word_value;
    end
    if (cmd.ld_msg) begin
      msg[word_index] <= word_value;
    end
    if (cmd.init) begin
      a   <= chain[0];
      b   <= chain[1];
      c   <= chain[2];
      d   <= chain[3];
      pre <= pre_next;
    end else if (cmd.round) begin
      a   <= d;
      b   <= b_new;
      c   <= b;
      d   <= c;
      pre <= pre_next;
    end
    if (cmd.finish) begin
      digest_a <= a + chain[0];
      digest_b <= b + chain[1];
      digest_c <= c + chain[2];
      digest_d <= d + chain[3];
    end
  end

endmodule

/* hdl/md5_block_compression.sv */
// Load beats (chaining or message word) can be taken back to back.
// A compute beat runs a setup state, 64 rounds on one shared round unit, then
// the final add into the output register, which waits while a held result is stalled.
// in_stall is high from the compute beat until the digest is registered.
// rst is synchronous: clears control and out_valid; stored words are not cleared.
module md5_block_compression (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                req_type,
  input  logic [md5_pkg::MsgW-1:0]  word_index,
  input  logic [md5_pkg::WordW-1:0] word_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [md5_pkg::WordW-1:0] digest_a,
  output logic [md5_pkg::WordW-1:0] digest_b,
  output logic [md5_pkg::WordW-1:0] digest_c,
  output logic [md5_pkg::WordW-1:0] digest_d
);
  import md5_pkg::*;

  dp_cmd_t cmd;

  md5_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (req_type),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  md5_dp u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .word_index (word_index),
    .word_value (word_value),
    .digest_a   (digest_a),
    .digest_b   (digest_b),
    .digest_c   (digest_c),
    .digest_d   (digest_d)
  );

endmodule

/* hdl/md5_chk.sv */
module md5_chk (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [1:0]                req_type,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [md5_pkg::WordW-1:0] digest_a,
  input logic [md5_pkg::WordW-1:0] digest_d
);
  import md5_pkg::*;

  logic in_beat;
  assign in_beat = in_valid && !in_stall;

  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid not cleared by reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digest_a) && $stable(digest_d))
    else $error("stalled digest changed");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    in_beat && (req_t'(req_type) == REQ_COMPUTE) |=> in_stall)
    else $error("compute beat did not stall input");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    in_beat && (req_t'(req_type) != REQ_COMPUTE) && !out_valid |=> !out_valid)
    else $error("result without compute");

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while input open");

endmodule

bind md5_block_compression md5_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .req_type  (req_type),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .digest_a  (digest_a),
  .digest_d  (digest_d)
);
